### rtl/core/sha384_pkg.sv
// Package with the SHA-384 constants, round functions and shared types.
`timescale 1ns / 1ps
package sha384_pkg;

  localparam int BlockWords  = 16;
  localparam int DigestWords = 6;
  localparam int CountBits   = 61;
  localparam int Rounds      = 80;

  typedef logic [63:0] word_t;

  localparam word_t PadWord = 64'h8000_0000_0000_0000;

  localparam word_t IvTable [8] = '{
    64'hCBBB9D5DC1059ED8, 64'h629A292A367CD507, 64'h9159015A3070DD17, 64'h152FECD8F70E5939,
    64'h67332667FFC00B31, 64'h8EB44A8768581511, 64'hDB0C2E0D64F98FA7, 64'h47B5481DBEFA4FA4
  };

  localparam word_t RcTable [80] = '{
    64'h428A2F98D728AE22, 64'h7137449123EF65CD, 64'hB5C0FBCFEC4D3B2F, 64'hE9B5DBA58189DBBC,
    64'h3956C25BF348B538, 64'h59F111F1B605D019, 64'h923F82A4AF194F9B, 64'hAB1C5ED5DA6D8118,
    64'hD807AA98A3030242, 64'h12835B0145706FBE, 64'h243185BE4EE4B28C, 64'h550C7DC3D5FFB4E2,
    64'h72BE5D74F27B896F, 64'h80DEB1FE3B1696B1, 64'h9BDC06A725C71235, 64'hC19BF174CF692694,
    64'hE49B69C19EF14AD2, 64'hEFBE4786384F25E3, 64'h0FC19DC68B8CD5B5, 64'h240CA1CC77AC9C65,
    64'h2DE92C6F592B0275, 64'h4A7484AA6EA6E483, 64'h5CB0A9DCBD41FBD4, 64'h76F988DA831153B5,
    64'h983E5152EE66DFAB, 64'hA831C66D2DB43210, 64'hB00327C898FB213F, 64'hBF597FC7BEEF0EE4,
    64'hC6E00BF33DA88FC2, 64'hD5A79147930AA725, 64'h06CA6351E003826F, 64'h142929670A0E6E70,
    64'h27B70A8546D22FFC, 64'h2E1B21385C26C926, 64'h4D2C6DFC5AC42AED, 64'h53380D139D95B3DF,
    64'h650A73548BAF63DE, 64'h766A0ABB3C77B2A8, 64'h81C2C92E47EDAEE6, 64'h92722C851482353B,
    64'hA2BFE8A14CF10364, 64'hA81A664BBC423001, 64'hC24B8B70D0F89791, 64'hC76C51A30654BE30,
    64'hD192E819D6EF5218, 64'hD69906245565A910, 64'hF40E35855771202A, 64'h106AA07032BBD1B8,
    64'h19A4C116B8D2D0C8, 64'h1E376C085141AB53, 64'h2748774CDF8EEB99, 64'h34B0BCB5E19B48A8,
    64'h391C0CB3C5C95A63, 64'h4ED8AA4AE3418ACB, 64'h5B9CCA4F7763E373, 64'h682E6FF3D6B2B8A3,
    64'h748F82EE5DEFB2FC, 64'h78A5636F43172F60, 64'h84C87814A1F0AB72, 64'h8CC702081A6439EC,
    64'h90BEFFFA23631E28, 64'hA4506CEBDE82BDE9, 64'hBEF9A3F7B2C67915, 64'hC67178F2E372532B,
    64'hCA273ECEEA26619C, 64'hD186B8C721C0C207, 64'hEADA7DD6CDE0EB1E, 64'hF57D4F7FEE6ED178,
    64'h06F067AA72176FBA, 64'h0A637DC5A2C898A6, 64'h113F9804BEF90DAE, 64'h1B710B35131C471B,
    64'h28DB77F523047D84, 64'h32CAAB7B40C72493, 64'h3C9EBE0A15C9BEBC, 64'h431D67C49C100D4C,
    64'h4CC5D4BECB3E42B6, 64'h597F299CFC657E2A, 64'h5FCB6FAB3AD6FAEC, 64'h6C44198C4A475817
  };

  // Handshake between the word sequencer and the round unit.
  typedef struct packed {
    logic start;  // compress the sixteen words in the block buffer
    logic init;   // reload the initial hash values (after a digest)
  } rnd_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;   // pulses in the cycle the chaining values are updated
  } rnd_sts_t;

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage

### rtl/core/sha384_hash_engine.sv
// Top level of the SHA-384 hash engine: input packing, padding and digest output.
`timescale 1ns / 1ps
// Usage: message beats arrive on data_i/nbytes_i/last_i with in_valid_i and
// in_stall_o; a beat is taken at a rising edge where in_valid_i is high and
// in_stall_o is low. Non-final beats carry eight bytes, big-endian. The beat
// with last_i set carries nbytes_i bytes (above eight counts as eight) from the
// top and closes the message; the engine adds padding and the bit length.
// Digest beats leave on digest_word_o/word_index_o/last_word_o with out_valid_o
// and out_stall_i: six beats, most significant word first, last_word_o on the
// sixth. The engine then reloads the initial hash values.
// Timing: a beat that does not complete a 128-byte block is taken without a
// stall. A beat that completes a block holds the input stalled while the
// shared round unit runs the rounds, updates the chaining values and hands
// back to the sequencer. The final beat costs one or two compressions,
// padding words being written one per cycle, and then the six digest beats.
// A stalled receiver simply holds the current digest beat; the input stays
// stalled until all six have been taken.
// Reset clears the counters and the state machine and reloads the initial
// hash values; the engine is ready to accept input as soon as reset is released.
module sha384_hash_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [63:0]          data_i,
  input  logic [3:0]           nbytes_i,
  input  logic                 last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [63:0]          digest_word_o,
  output logic [2:0]           word_index_o,
  output logic                 last_word_o
);
  import sha384_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StComp = 3'd1;  // compressing a full data block
  localparam logic [2:0] StPad  = 3'd2;  // writing zero and length words
  localparam logic [2:0] StPadC = 3'd3;  // compressing during padding
  localparam logic [2:0] StOut  = 3'd4;

  // Padding phase, kept in idx_q while padding.
  localparam logic [2:0] PadLen  = 3'd0;  // length goes in slot 15 of this block
  localparam logic [2:0] PadMark = 3'd1;  // pad marker still owed
  localparam logic [2:0] PadDone = 3'd2;  // length block is being compressed
  localparam logic [2:0] PadSkip = 3'd3;  // no room for the length, zero fill only

  logic [2:0]            st_q, st_d;
  logic [3:0]            pos_q, pos_d;
  logic [CountBits-1:0]  cnt_q, cnt_d;
  logic [2:0]            idx_q, idx_d;
  word_t                 blk_q [16];
  logic                  wr_en;
  logic [3:0]            wr_addr;
  word_t                 wr_data;
  rnd_ctl_t              ctl;
  rnd_sts_t              sts;
  word_t                 hash [8];
  logic                  in_acc;
  logic [3:0]            nb;
  word_t                 keep, fin_word;
  logic [CountBits-1:0]  cnt_sum;
  logic                  u_round_busy_free;

  assign in_acc = in_valid_i && !in_stall_o;
  assign nb     = (nbytes_i > 4'd8) ? 4'd8 : nbytes_i;
  assign cnt_sum = cnt_q + (last_i ? CountBits'(nb) : CountBits'(8));

  // Keep the top nb bytes and put the pad marker right after them.
  always_comb begin
    keep = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) keep[63-8*i -: 8] = 8'hFF;
    end
    fin_word = data_i & keep;
    if (nb != 4'd8) fin_word[63 - 8*nb[2:0] -: 8] = 8'h80;
  end

  // The length word needs slots 14 and 15; a pad marker in slot 14 or 15
  // pushes the length into an extra block.
  always_comb begin
    st_d     = st_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    wr_en    = 1'b0;
    wr_addr  = pos_q;
    wr_data  = '0;
    ctl      = '0;
    unique case (st_q)
      StIdle: begin
        if (in_acc) begin
          cnt_d   = cnt_sum;
          wr_en   = 1'b1;
          wr_data = (last_i) ? fin_word : data_i;
          pos_d   = pos_q + 4'd1;
          if (last_i) begin
            // A full final word leaves the pad marker for the next position.
            if (nb == 4'd8) begin
              wr_data = data_i;
              st_d    = StPad;
              idx_d   = PadMark;
            end else begin
              st_d  = StPad;
              idx_d = (pos_q == 4'd14) ? PadSkip : PadLen;
            end
            if (pos_q == 4'd15) begin
              ctl.start = 1'b1;
              st_d      = StPadC;
            end
          end else if (pos_q == 4'd15) begin
            ctl.start = 1'b1;
            st_d      = StComp;
          end
        end
      end
      StComp: begin
        if (sts.done) st_d = StIdle;
      end
      StPad: begin
        wr_en = 1'b1;
        pos_d = pos_q + 4'd1;
        if (idx_q == PadMark) begin
          wr_data = PadWord;
          idx_d   = (pos_q == 4'd14) ? PadSkip : PadLen;
        end else if (idx_q == PadLen && pos_q == 4'd15) begin
          wr_data = {cnt_q, 3'b000};
        end
        if (pos_q == 4'd15) begin
          ctl.start = 1'b1;
          st_d      = StPadC;
          // Only a length-bearing block ends the message.
          if (idx_q == PadLen) idx_d = PadDone;
          else if (idx_q == PadSkip) idx_d = PadLen;
        end
      end
      StPadC: begin
        if (sts.done) begin
          if (idx_q == PadDone) begin
            st_d  = StOut;
            idx_d = 3'd0;
          end else begin
            st_d = StPad;
          end
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          if (idx_q == 3'(DigestWords - 1)) begin
            st_d     = StIdle;
            idx_d    = 3'd0;
            cnt_d    = '0;
            pos_d    = '0;
            ctl.init = 1'b1;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= StIdle;
      pos_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      st_q  <= st_d;
      pos_q <= pos_d;
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) blk_q[wr_addr] <= wr_data;
  end

  sha384_round u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .blk_i  (blk_q),
    .sts_o  (sts),
    .hash_o (hash)
  );

  assign in_stall_o    = (st_q != StIdle);
  assign out_valid_o   = (st_q == StOut);
  assign digest_word_o = hash[idx_q];
  assign word_index_o  = idx_q;
  assign last_word_o   = (idx_q == 3'(DigestWords - 1));

  assign u_round_busy_free = (st_q == StComp) || (st_q == StPadC);

  a_out_only_idle_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("output while accepting input");
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> idx_q < 3'(DigestWords)) else $error("digest index out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(idx_q))
    else $error("digest beat dropped under stall");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.start |-> !u_round_busy_free) else $error("start while busy");

endmodule

### rtl/core/sha384_round.sv
// Iterative SHA-384 compression unit: one round per cycle over a shared datapath.
`timescale 1ns / 1ps
module sha384_round (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sha384_pkg::rnd_ctl_t        ctl_i,
  input  sha384_pkg::word_t           blk_i [16],
  output sha384_pkg::rnd_sts_t        sts_o,
  output sha384_pkg::word_t           hash_o [8]
);
  import sha384_pkg::*;

  word_t       h_q [8];
  word_t       v_q [8];
  word_t       w_q [16];
  logic        busy_q;
  logic        done_q;
  logic [6:0]  rnd_q;

  word_t w_new, t1, t2;

  // Message schedule: the window shifts by one word per round, w_q[15] newest.
  always_comb begin
    if (rnd_q < 7'd16) begin
      w_new = blk_i[rnd_q[3:0]];
    end else begin
      w_new = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];
    end
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + w_new + RcTable[rnd_q];
    t2 = big_sigma0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      rnd_q  <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= IvTable[i];
    end else begin
      done_q <= 1'b0;
      if (ctl_i.init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= IvTable[i];
      end
      if (ctl_i.start && !busy_q) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        if (rnd_q == 7'(Rounds)) begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          busy_q <= 1'b0;
          done_q <= 1'b1;
          rnd_q  <= '0;
        end else begin
          rnd_q <= rnd_q + 7'd1;
        end
      end
    end
  end

  // Working variables load on start and step once per round.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start && !busy_q) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (busy_q && rnd_q != 7'(Rounds)) begin
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_new;
    end
  end

  assign sts_o.busy = busy_q | ctl_i.start;
  assign sts_o.done = done_q;
  assign hash_o     = h_q;

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_round_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rnd_q <= 7'(Rounds)) else $error("round counter out of range");
  a_idle_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> rnd_q == 7'd0) else $error("round counter not cleared");

endmodule
